>>> src/dhcpoe_pkg.sv
// ----------------------------------------------------------------------------
// DHCP option extractor package
// Shared request and result types, option codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dhcpoe_pkg;

   // One byte of the option block.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_last;
   } req_type;

   // One parse result, emitted on the last byte of a block.
   typedef struct packed {
      logic [7:0]  message_type;
      logic        message_type_valid;
      logic [31:0] server_ident;
      logic        server_ident_valid;
      logic [31:0] subnet_value;
      logic        subnet_valid;
      logic [31:0] router_addr;
      logic        router_valid;
      logic [31:0] dns_addr;
      logic        dns_valid;
      logic [1:0]  parse_status;
   } rsp_type;

   // A registered byte waiting for the parser.
   typedef struct packed {
      logic    valid;
      req_type req;
   } stage_type;

   typedef enum logic [1:0] {
      PH_CODE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_VALUE = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   localparam logic [7:0] OPT_PAD    = 8'd0;
   localparam logic [7:0] OPT_SUBNET = 8'd1;
   localparam logic [7:0] OPT_ROUTER = 8'd3;
   localparam logic [7:0] OPT_DNS    = 8'd6;
   localparam logic [7:0] OPT_TYPE   = 8'd53;
   localparam logic [7:0] OPT_SERVER = 8'd54;
   localparam logic [7:0] OPT_END    = 8'd255;

   localparam logic [2:0] WORD_BYTES = 3'd4;

   localparam logic [1:0] STATUS_END      = 2'd0;
   localparam logic [1:0] STATUS_BOUNDARY = 2'd1;
   localparam logic [1:0] STATUS_TRUNC    = 2'd2;

   // Bit positions in the captured-value flag vector.
   localparam int FLAG_TYPE   = 0;
   localparam int FLAG_SERVER = 1;
   localparam int FLAG_SUBNET = 2;
   localparam int FLAG_ROUTER = 3;
   localparam int FLAG_DNS    = 4;

endpackage

`default_nettype wire

>>> src/dhcpoe_in_reg.sv
// ----------------------------------------------------------------------------
// DHCP option extractor input register
// Holds one incoming byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcpoe_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire dhcpoe_pkg::req_type   req_data,
   input  wire logic                  consume,
   output dhcpoe_pkg::stage_type      stage
);
   import dhcpoe_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    load;

   // The register is refilled whenever it is empty or its byte moves on.
   assign req_stall = valid_ff && !consume;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = load ? 1'b1 : (valid_ff && !consume);
      data_in  = load ? req_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign stage.valid = valid_ff;
   assign stage.req   = data_ff;

endmodule

`default_nettype wire

>>> src/dhcpoe_parser.sv
// ----------------------------------------------------------------------------
// DHCP option extractor parser
// Walks code/length/value fields one byte per cycle while fired; holds captures.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcpoe_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire dhcpoe_pkg::req_type   item,
   output dhcpoe_pkg::rsp_type        result
);
   import dhcpoe_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  left_ff, left_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] accum_ff, accum_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] server_ff, server_in;
   logic [31:0] subnet_ff, subnet_in;
   logic [31:0] router_ff, router_in;
   logic [31:0] dns_ff, dns_in;
   logic [4:0]  flags_ff, flags_in;

   logic [7:0]  left_dec;
   logic        commit;
   logic [1:0]  status;
   logic [7:0]  b;

   assign b = item.data_byte;

   always_comb begin
      phase_in  = phase_ff;
      code_in   = code_ff;
      left_in   = left_ff;
      count_in  = count_ff;
      accum_in  = accum_ff;
      first_in  = first_ff;
      type_in   = type_ff;
      server_in = server_ff;
      subnet_in = subnet_ff;
      router_in = router_ff;
      dns_in    = dns_ff;
      flags_in  = flags_ff;
      commit    = 1'b0;
      left_dec  = (left_ff != 8'd0) ? left_ff - 8'd1 : 8'd0;

      if (fire) begin
         unique case (phase_ff)
            PH_CODE: begin
               if (b == OPT_END) begin
                  phase_in = PH_DONE;
               end else if (b != OPT_PAD) begin
                  code_in  = b;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               left_in  = b;
               count_in = 3'd0;
               accum_in = 32'd0;
               phase_in = (b == 8'd0) ? PH_CODE : PH_VALUE;
            end
            PH_VALUE: begin
               if (count_ff < WORD_BYTES) begin
                  accum_in = {accum_ff[23:0], b};
                  count_in = count_ff + 3'd1;
               end
               if (count_ff == 3'd0) begin
                  first_in = b;
               end
               left_in = left_dec;
               if (left_dec == 8'd0) begin
                  commit   = 1'b1;
                  phase_in = PH_CODE;
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
      end

      // Store the option that just completed. The message type is the
      // first value byte; the address options need at least four bytes.
      if (commit) begin
         if (code_in == OPT_TYPE) begin
            type_in             = first_in;
            flags_in[FLAG_TYPE] = 1'b1;
         end else if (count_in == WORD_BYTES) begin
            unique case (code_in)
               OPT_SERVER: begin
                  server_in             = accum_in;
                  flags_in[FLAG_SERVER] = 1'b1;
               end
               OPT_SUBNET: begin
                  subnet_in             = accum_in;
                  flags_in[FLAG_SUBNET] = 1'b1;
               end
               OPT_ROUTER: begin
                  router_in             = accum_in;
                  flags_in[FLAG_ROUTER] = 1'b1;
               end
               OPT_DNS: begin
                  dns_in             = accum_in;
                  flags_in[FLAG_DNS] = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end

      unique case (phase_in)
         PH_DONE: status = STATUS_END;
         PH_CODE: status = STATUS_BOUNDARY;
         default: status = STATUS_TRUNC;
      endcase

      result.message_type       = flags_in[FLAG_TYPE] ? type_in : 8'd0;
      result.message_type_valid = flags_in[FLAG_TYPE];
      result.server_ident       = flags_in[FLAG_SERVER] ? server_in : 32'd0;
      result.server_ident_valid = flags_in[FLAG_SERVER];
      result.subnet_value       = flags_in[FLAG_SUBNET] ? subnet_in : 32'd0;
      result.subnet_valid       = flags_in[FLAG_SUBNET];
      result.router_addr        = flags_in[FLAG_ROUTER] ? router_in : 32'd0;
      result.router_valid       = flags_in[FLAG_ROUTER];
      result.dns_addr           = flags_in[FLAG_DNS] ? dns_in : 32'd0;
      result.dns_valid          = flags_in[FLAG_DNS];
      result.parse_status       = status;
   end

   // The last byte of a block returns every register to its reset value.
   always_ff @(posedge clock) begin
      if (reset || (fire && item.block_last)) begin
         phase_ff  <= PH_CODE;
         code_ff   <= 8'd0;
         left_ff   <= 8'd0;
         count_ff  <= 3'd0;
         accum_ff  <= 32'd0;
         first_ff  <= 8'd0;
         type_ff   <= 8'd0;
         server_ff <= 32'd0;
         subnet_ff <= 32'd0;
         router_ff <= 32'd0;
         dns_ff    <= 32'd0;
         flags_ff  <= 5'd0;
      end else begin
         phase_ff  <= phase_in;
         code_ff   <= code_in;
         left_ff   <= left_in;
         count_ff  <= count_in;
         accum_ff  <= accum_in;
         first_ff  <= first_in;
         type_ff   <= type_in;
         server_ff <= server_in;
         subnet_ff <= subnet_in;
         router_ff <= router_in;
         dns_ff    <= dns_in;
         flags_ff  <= flags_in;
      end
   end

endmodule

`default_nettype wire

>>> src/dhcp_option_extractor_unit.sv
// ----------------------------------------------------------------------------
// DHCP option extractor
// Streaming parser of a DHCP option block with one result per block.
// ----------------------------------------------------------------------------
// The block takes a DHCP option block one byte per request, with block_last
// set on the final byte, and sustains one request every clock cycle unless
// stalled as described below. Each byte lands in an input register, from
// which the parser walks the code, length and value fields and updates its
// captured values; the result of a block is registered in an output register
// and appears on the response channel from it. Pad bytes are skipped, and
// after an end option the remaining bytes are ignored. The message type, the
// server identifier, the subnet mask, the first router and the first DNS
// server are captured when their option lies wholly inside the block, with a
// later instance replacing an earlier one; a value whose valid flag is clear
// reads as zero. The status tells whether the end option was seen, the data
// ran out at an option boundary, or the block ended inside an option. The
// input side only stalls while a block's last byte waits for a response that
// is itself still stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_option_extractor_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire dhcpoe_pkg::req_type  req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output dhcpoe_pkg::rsp_type       rsp_data
);
   import dhcpoe_pkg::*;

   stage_type stage;
   rsp_type   result;
   logic      out_free;
   logic      fire;
   logic      emit;

   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   dhcpoe_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .consume   (fire),
      .stage     (stage)
   );

   // Ordinary bytes never wait. A last byte waits only while the output
   // register still holds a response that the receiver has not taken.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = stage.valid && (!stage.req.block_last || out_free);
   assign emit     = fire && stage.req.block_last;

   dhcpoe_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (stage.req),
      .result (result)
   );

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> src/dhcpoe_checker.sv
// ----------------------------------------------------------------------------
// DHCP option extractor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcpoe_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire dhcpoe_pkg::req_type  req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire dhcpoe_pkg::rsp_type  rsp_data
);
   import dhcpoe_pkg::*;

   // A stalled response stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A new response follows a last byte accepted through the input and output registers.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && !req_stall && req_data.block_last, 2))
      else $error("response without a preceding last byte");

   // The status code never takes the unused value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.parse_status == STATUS_END ||
                     rsp_data.parse_status == STATUS_BOUNDARY ||
                     rsp_data.parse_status == STATUS_TRUNC))
      else $error("bad parse status");

   // Values without their valid flag read as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.message_type_valid || rsp_data.message_type == 8'd0) &&
         (rsp_data.server_ident_valid || rsp_data.server_ident == 32'd0) &&
         (rsp_data.subnet_valid || rsp_data.subnet_value == 32'd0) &&
         (rsp_data.router_valid || rsp_data.router_addr == 32'd0) &&
         (rsp_data.dns_valid || rsp_data.dns_addr == 32'd0))
      else $error("invalid field is not zero");

endmodule

bind dhcp_option_extractor_unit dhcpoe_checker u_dhcpoe_checker (.*);

`default_nettype wire
